>>> design/fbq_pkg.sv
// Shared types and constants of the three-level feedback queue scheduler.
// Used by the channel interfaces, the divider, the task store and the top level.
`timescale 1ns / 1ps

package fbq_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned ID_W    = 16;
  localparam int unsigned QUANT_W = 16;
  localparam int unsigned ITER_W  = 16;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned INTV_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LVL_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Request codes
  localparam logic REQ_ADD      = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  // Add status codes
  localparam logic [STAT_W-1:0] ADD_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ADD_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ADD_INVALID = 2'd2;

  // Priority levels, top first
  localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW = 2'd2;
  localparam int unsigned NUM_LEVELS = 3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_PROMO_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THREADS        = 2'd1;
  localparam logic [INTV_W-1:0]    RESET_INTERVAL     = 16'd60;
  localparam logic [THR_W-1:0]     RESET_THREADS      = 8'd1;

  // One stored task
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [QUANT_W-1:0] quantum;
    logic [ITER_W-1:0]  iterations;
  } task_t;

  // One result beat
  typedef struct packed {
    logic [STAT_W-1:0]  add_status;
    logic               dispatched;
    logic [ID_W-1:0]    run_id;
    logic [LVL_W-1:0]   run_level;
    logic [QUANT_W-1:0] slice_time;
    logic [ITER_W-1:0]  iterations_left;
    logic               finished;
    logic               promoted;
  } res_t;

  // Divider handshake
  typedef struct packed {
    logic               start;
    logic [QUANT_W-1:0] dividend;
    logic [THR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [QUANT_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/fbq_if.sv
// Valid/ready channel interfaces of the scheduler: requests, results, config writes.
// Depends on fbq_pkg for field widths.
`timescale 1ns / 1ps

interface fbq_req_if import fbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ID_W-1:0]    task_id;
  logic [QUANT_W-1:0] task_quantum;
  logic [ITER_W-1:0]  task_iterations;

  modport source (output valid, req_type, task_id, task_quantum, task_iterations,
                  input ready);
  modport sink   (input valid, req_type, task_id, task_quantum, task_iterations,
                  output ready);
endinterface

interface fbq_res_if import fbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  add_status;
  logic               dispatched;
  logic [ID_W-1:0]    run_id;
  logic [LVL_W-1:0]   run_level;
  logic [QUANT_W-1:0] slice_time;
  logic [ITER_W-1:0]  iterations_left;
  logic               finished;
  logic               promoted;

  modport source (output valid, add_status, dispatched, run_id, run_level, slice_time,
                         iterations_left, finished, promoted,
                  input ready);
  modport sink   (input valid, add_status, dispatched, run_id, run_level, slice_time,
                        iterations_left, finished, promoted,
                  output ready);
endinterface

interface fbq_cfg_if import fbq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/fbq_div.sv
// Restoring divider, one quotient bit per cycle: quantum / threads.
// Depends on fbq_pkg for the request and response structs.
`timescale 1ns / 1ps

module fbq_div import fbq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(QUANT_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [QUANT_W-1:0] quo_q, quo_d;
  logic [THR_W-1:0]   rem_q, rem_d;
  logic [THR_W-1:0]   dvs_q, dvs_d;
  logic [THR_W:0]     rem_shift;

  // One shift-subtract step per cycle
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    step_d    = step_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    rem_shift = {rem_q, quo_q[QUANT_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, dvs_q}) begin
        rem_d = THR_W'(rem_shift - {1'b0, dvs_q});
        quo_d = {quo_q[QUANT_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[THR_W-1:0];
        quo_d = {quo_q[QUANT_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(QUANT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> design/fbq_store.sv
// Task store: one synchronous RAM holding the three level rings back to back.
// Depends on fbq_pkg for task_t and level codes; read data is registered.
`timescale 1ns / 1ps

module fbq_store import fbq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [LVL_W-1:0]            wr_lvl_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_slot_i,
  input  task_t                       wr_data_i,
  input  logic                        rd_en_i,
  input  logic [LVL_W-1:0]            rd_lvl_i,
  input  logic [$clog2(CAPACITY)-1:0] rd_slot_i,
  output task_t                       rd_data_o
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned DEPTH  = NUM_LEVELS * CAPACITY;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  task_t mem [DEPTH];
  task_t rd_data_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  // Level ring base plus slot
  function automatic logic [ADDR_W-1:0] lvl_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [SLOT_W-1:0] slot);
    logic [ADDR_W-1:0] base;
    case (lvl)
      LVL_TOP: base = '0;
      LVL_MID: base = ADDR_W'(CAPACITY);
      default: base = ADDR_W'(2 * CAPACITY);
    endcase
    return base + ADDR_W'(slot);
  endfunction

  assign wr_addr = lvl_addr(wr_lvl_i, wr_slot_i);
  assign rd_addr = lvl_addr(rd_lvl_i, rd_slot_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/three_level_feedback_queue_scheduler.sv
// Three-level feedback queue scheduler, top level: sequencer, level bookkeeping, registers.
// Depends on fbq_pkg, the fbq_*_if interfaces, fbq_store and fbq_div.
//
// Usage: requests arrive on req_i (valid/ready). An add beat stores a task at the tail
// of the top level; a dispatch beat ages the lower levels if due, runs the head of the
// highest non-empty level and re-queues it one level lower unless it finished. Every
// request yields exactly one result beat on res_o. Registers promotion interval (index
// 0) and threads per processor (index 1) are written on cfg_i, which is always ready.
// Flow: req_i takes one beat at a time. An add, and a dispatch on an empty store, go
// straight to the result step. A dispatch with entries reads the head, writes it back
// one level lower unless it finished, then divides; when aging is due it first moves M
// entries to the top level (M at most TASK_CAPACITY): each move is a read then a write
// on the task RAM, one more step finds each lower level empty, and the slice time comes
// from a 16-step bit-serial divider. The result register lets the next request be taken
// while a result waits; a stalled res_o only holds the block at its final step.
// Reset empties all levels, clears time counters and loads the register defaults; the
// task RAM needs no clearing since only written entries are ever read.
`timescale 1ns / 1ps

module three_level_feedback_queue_scheduler import fbq_pkg::*; #(
  parameter int unsigned TASK_CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbq_req_if.sink    req_i,
  fbq_res_if.source  res_o,
  fbq_cfg_if.sink    cfg_i
);

  localparam int unsigned SLOT_W = $clog2(TASK_CAPACITY);
  localparam int unsigned CNT_W  = $clog2(TASK_CAPACITY + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PROM_RD = 3'd1;
  localparam logic [2:0] ST_PROM_WR = 3'd2;
  localparam logic [2:0] ST_POP_RD  = 3'd3;
  localparam logic [2:0] ST_POP_WB  = 3'd4;
  localparam logic [2:0] ST_DIV     = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] head_q  [NUM_LEVELS];
  logic [SLOT_W-1:0] head_d  [NUM_LEVELS];
  logic [CNT_W-1:0]  count_q [NUM_LEVELS];
  logic [CNT_W-1:0]  count_d [NUM_LEVELS];
  logic [CNT_W-1:0]  total_q, total_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] last_promo_q, last_promo_d;
  logic [INTV_W-1:0] interval_q;
  logic [THR_W-1:0]  threads_q;
  logic [LVL_W-1:0]  src_q, src_d;
  res_t              pend_q, pend_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Task RAM ports
  logic              wr_en, rd_en;
  logic [LVL_W-1:0]  wr_lvl, rd_lvl;
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  task_t             wr_data, rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_beat;
  logic              add_bad;
  logic [LVL_W-1:0]  pop_lvl;
  logic [LVL_W-1:0]  nxt_lvl;
  logic [ITER_W-1:0] iter_new;

  // Ring arithmetic, capacity need not be a power of two
  function automatic logic [SLOT_W-1:0] tail_slot(input logic [SLOT_W-1:0] h,
                                                  input logic [CNT_W-1:0]  c);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(c);
    if (s >= (CNT_W+1)'(TASK_CAPACITY)) begin
      s = s - (CNT_W+1)'(TASK_CAPACITY);
    end
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] h);
    logic [SLOT_W-1:0] n;
    if (h == SLOT_W'(TASK_CAPACITY - 1)) begin
      n = '0;
    end else begin
      n = h + 1'b1;
    end
    return n;
  endfunction

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_beat     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign add_bad     = (req_i.task_id == '0) || (req_i.task_quantum == '0) ||
                       (req_i.task_iterations == '0);

  // Highest non-empty level for the pop
  always_comb begin
    if (count_q[LVL_TOP] != '0) begin
      pop_lvl = LVL_TOP;
    end else if (count_q[LVL_MID] != '0) begin
      pop_lvl = LVL_MID;
    end else begin
      pop_lvl = LVL_LOW;
    end
  end

  // Feedback: one level lower, bottom level stays put
  assign nxt_lvl  = (pend_q.run_level == LVL_TOP) ? LVL_MID : LVL_LOW;
  assign iter_new = (rd_data.iterations != '0) ? rd_data.iterations - 1'b1 : '0;

  // Sequencer: read, modify, write back on the task RAM
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    total_d      = total_q;
    time_d       = time_q;
    last_promo_d = last_promo_q;
    src_d        = src_q;
    pend_d       = pend_q;
    wr_en        = 1'b0;
    wr_lvl       = LVL_TOP;
    wr_slot      = tail_slot(head_q[LVL_TOP], count_q[LVL_TOP]);
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_lvl       = src_q;
    rd_slot      = head_q[src_q];
    div_req.start    = 1'b0;
    div_req.dividend = rd_data.quantum;
    div_req.divisor  = (threads_q == '0) ? THR_W'(1) : threads_q;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          pend_d  = '0;
          state_d = ST_FIN;
          if (req_i.req_type == REQ_ADD) begin
            if (add_bad) begin
              pend_d.add_status = ADD_INVALID;
            end else if (total_q >= CNT_W'(TASK_CAPACITY)) begin
              pend_d.add_status = ADD_FULL;
            end else begin
              pend_d.add_status  = ADD_OK;
              wr_en              = 1'b1;
              wr_data.id         = req_i.task_id;
              wr_data.quantum    = req_i.task_quantum;
              wr_data.iterations = req_i.task_iterations;
              count_d[LVL_TOP]   = count_q[LVL_TOP] + 1'b1;
              total_d            = total_q + 1'b1;
            end
          end else if (total_q != '0) begin
            // Aging check on wrapping time difference
            if ((time_q - last_promo_q) >= TIME_W'(interval_q)) begin
              pend_d.promoted = 1'b1;
              last_promo_d    = time_q;
              src_d           = LVL_MID;
              state_d         = ST_PROM_RD;
            end else begin
              state_d = ST_POP_RD;
            end
          end
        end
      end
      ST_PROM_RD: begin
        if (count_q[src_q] == '0) begin
          if (src_q == LVL_MID) begin
            src_d = LVL_LOW;
          end else begin
            state_d = ST_POP_RD;
          end
        end else begin
          rd_en          = 1'b1;
          head_d[src_q]  = next_slot(head_q[src_q]);
          count_d[src_q] = count_q[src_q] - 1'b1;
          state_d        = ST_PROM_WR;
        end
      end
      ST_PROM_WR: begin
        wr_en            = 1'b1;
        count_d[LVL_TOP] = count_q[LVL_TOP] + 1'b1;
        state_d          = ST_PROM_RD;
      end
      ST_POP_RD: begin
        rd_en            = 1'b1;
        rd_lvl           = pop_lvl;
        rd_slot          = head_q[pop_lvl];
        head_d[pop_lvl]  = next_slot(head_q[pop_lvl]);
        count_d[pop_lvl] = count_q[pop_lvl] - 1'b1;
        pend_d.run_level = pop_lvl;
        state_d          = ST_POP_WB;
      end
      ST_POP_WB: begin
        pend_d.dispatched      = 1'b1;
        pend_d.run_id          = rd_data.id;
        pend_d.iterations_left = iter_new;
        time_d                 = time_q + TIME_W'(rd_data.quantum);
        div_req.start          = 1'b1;
        if (iter_new == '0) begin
          pend_d.finished = 1'b1;
          total_d         = total_q - 1'b1;
        end else begin
          wr_en              = 1'b1;
          wr_lvl             = nxt_lvl;
          wr_slot            = tail_slot(head_q[nxt_lvl], count_q[nxt_lvl]);
          wr_data.iterations = iter_new;
          count_d[nxt_lvl]   = count_q[nxt_lvl] + 1'b1;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pend_d.slice_time = div_rsp.quotient;
          state_d           = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register, loaded when the sequencer finishes
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    if (state_q == ST_FIN && (!out_valid_q || res_o.ready)) begin
      out_d       = pend_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      total_q      <= '0;
      time_q       <= '0;
      last_promo_q <= '0;
      src_q        <= LVL_MID;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      time_q       <= time_d;
      last_promo_q <= last_promo_d;
      src_q        <= src_d;
      out_valid_q  <= out_valid_d;
      head_q       <= head_d;
      count_q      <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= RESET_INTERVAL;
      threads_q  <= RESET_THREADS;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_PROMO_INTERVAL: interval_q <= cfg_i.data[INTV_W-1:0];
        CFG_THREADS:        threads_q  <= cfg_i.data[THR_W-1:0];
        default:            ;
      endcase
    end
  end

  fbq_store #(
    .CAPACITY (TASK_CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_lvl_i  (wr_lvl),
    .wr_slot_i (wr_slot),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_lvl_i  (rd_lvl),
    .rd_slot_i (rd_slot),
    .rd_data_o (rd_data)
  );

  fbq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.add_status      = out_q.add_status;
  assign res_o.dispatched      = out_q.dispatched;
  assign res_o.run_id          = out_q.run_id;
  assign res_o.run_level       = out_q.run_level;
  assign res_o.slice_time      = out_q.slice_time;
  assign res_o.iterations_left = out_q.iterations_left;
  assign res_o.finished        = out_q.finished;
  assign res_o.promoted        = out_q.promoted;

  // Checks
  logic [CNT_W+1:0] count_sum;
  assign count_sum = (CNT_W+2)'(count_q[LVL_TOP]) + (CNT_W+2)'(count_q[LVL_MID]) +
                     (CNT_W+2)'(count_q[LVL_LOW]);

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(TASK_CAPACITY))
    else $error("task total above capacity");

  a_levels_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (count_sum == (CNT_W+2)'(total_q)))
    else $error("level counts disagree with task total");

  a_promo_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_RD && pend_q.promoted) |->
      (count_q[LVL_MID] == '0 && count_q[LVL_LOW] == '0))
    else $error("aging left entries in lower levels");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide step");

endmodule
